// ----- sv/ssoc_pkg.sv -----
// ----------------------------------------------------------------------------
// Subsequence occurrence counter package
// Shared types and constants for the counter cells, the channel interfaces
// and the top level.
// ----------------------------------------------------------------------------
package ssoc_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int COUNT_BITS_DEF  = 32;

   localparam int KEY_BITS       = 64;
   localparam int ACTION_BITS    = 2;
   localparam int COUNT_OUT_BITS = 32;
   localparam int LEN_OUT_BITS   = 5;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_TEXT    = 2'd2
   } action_type;

   // Broadcast from the top level to every cell of the row.
   typedef struct packed {
      logic                zero_counts;
      logic                text_step;
      logic [KEY_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

// ----- sv/ssoc_if.sv -----
// ----------------------------------------------------------------------------
// Subsequence occurrence counter channels
// Valid/ready interfaces for the request and the response channels.
// ----------------------------------------------------------------------------
interface ssoc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ssoc_pkg::ACTION_BITS-1:0]     action;
   logic [ssoc_pkg::KEY_BITS-1:0]        value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface ssoc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ssoc_pkg::COUNT_OUT_BITS-1:0]  count;
   logic                                 saturated;
   logic [ssoc_pkg::LEN_OUT_BITS-1:0]    pattern_length;
   logic                                 pattern_overflow;

   modport source (output valid, output count, output saturated,
                   output pattern_length, output pattern_overflow, input ready);
   modport sink   (input valid, input count, input saturated,
                   input pattern_length, input pattern_overflow, output ready);
endinterface

// ----- sv/ssoc_cell.sv -----
// ----------------------------------------------------------------------------
// Subsequence occurrence counter cell
// Holds one pattern key and the partial count for its position, and adds the
// count of the cell before it when a text key matches.
// ----------------------------------------------------------------------------
module ssoc_cell #(
   parameter int COUNT_BITS = ssoc_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssoc_pkg::cell_ctrl_type ctrl,
   input  logic                    load_en,
   input  logic                    active,
   input  logic [COUNT_BITS-1:0]   lower_count,
   output logic [COUNT_BITS-1:0]   count_out,
   output logic [COUNT_BITS-1:0]   count_next,
   output logic                    sat_hit
);
   import ssoc_pkg::*;

   localparam logic [COUNT_BITS:0] SUM_MAX = {1'b0, {COUNT_BITS{1'b1}}};

   logic [KEY_BITS-1:0]   key_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS:0]   sum;
   logic                  hit;
   logic                  at_max;

   always_comb begin
      sum    = {1'b0, count_ff} + {1'b0, lower_count};
      at_max = (sum >= SUM_MAX);
      hit    = ctrl.text_step && active && (key_ff == ctrl.key);
      if (ctrl.zero_counts) begin
         count_in = '0;
      end else if (hit) begin
         count_in = at_max ? SUM_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Pattern keys are only ever read below the loaded length, so no reset.
   always_ff @(posedge clock) begin
      if (load_en) begin
         key_ff <= ctrl.key;
      end
   end

   assign count_out  = count_ff;
   assign count_next = count_in;
   assign sat_hit    = hit && at_max;

endmodule

// ----- sv/subsequence_occurrence_counter.sv -----
// ----------------------------------------------------------------------------
// Subsequence occurrence counter
// Counts the ways a loaded pattern of 64-bit keys occurs in order, not
// necessarily contiguously, in a streamed text of keys.
// ----------------------------------------------------------------------------
// Each request beat is clear, append a pattern key or feed a text key, and
// each one returns exactly one response beat with the count for the whole
// pattern, the sticky saturation and overflow flags and the pattern length.
// A row of MAX_PATTERN cells holds one pattern key and one partial count per
// position; a text key updates every cell at once from the counts of the
// previous cycle, so one beat is accepted per clock and its response appears
// in the output register on the following cycle. The response register
// lets a new beat in while the previous response is being taken; throughput
// drops only when the sink holds ready low. No clearing pass is needed after
// reset.
module subsequence_occurrence_counter #(
   parameter int MAX_PATTERN = ssoc_pkg::MAX_PATTERN_DEF,
   parameter int COUNT_BITS  = ssoc_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   ssoc_req_if.sink    req_bus,
   ssoc_rsp_if.source  rsp_bus
);
   import ssoc_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

   logic                      accept;
   action_type                action;
   cell_ctrl_type             ctrl;

   logic [LEN_W-1:0]          len_ff, len_in;
   logic                      sat_ff, sat_in;
   logic                      ovf_ff, ovf_in;
   logic                      append;

   logic [COUNT_BITS-1:0]     count_q    [MAX_PATTERN];
   logic [COUNT_BITS-1:0]     count_next [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]    sat_hits;
   logic [MAX_PATTERN-1:0]    load_en;
   logic [MAX_PATTERN-1:0]    active;

   logic [LEN_W-1:0]          last_pos;
   logic [COUNT_BITS-1:0]     total;
   logic [COUNT_BITS+COUNT_OUT_BITS-1:0] total_wide;
   logic [LEN_W+LEN_OUT_BITS-1:0]        len_wide;

   logic                      rsp_valid_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic                      rsp_sat_ff;
   logic [LEN_OUT_BITS-1:0]   rsp_len_ff;
   logic                      rsp_ovf_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign action        = action_type'(req_bus.action);

   always_comb begin
      ctrl.zero_counts = 1'b0;
      ctrl.text_step   = 1'b0;
      ctrl.key         = req_bus.value;
      append           = 1'b0;
      len_in           = len_ff;
      sat_in           = sat_ff;
      ovf_in           = ovf_ff;
      if (accept) begin
         case (action)
            ACT_CLEAR: begin
               ctrl.zero_counts = 1'b1;
               len_in           = '0;
               sat_in           = 1'b0;
               ovf_in           = 1'b0;
            end
            ACT_PATTERN: begin
               ctrl.zero_counts = 1'b1;
               if (len_ff < LEN_FULL) begin
                  append = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            ACT_TEXT: begin
               ctrl.text_step = 1'b1;
               sat_in         = sat_ff || (|sat_hits);
            end
            default: begin
            end
         endcase
      end
   end

   genvar j;
   generate
      for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
         logic [COUNT_BITS-1:0] lower;

         if (j == 0) begin : g_first
            assign lower = COUNT_BITS'(1);
         end else begin : g_rest
            assign lower = count_q[j-1];
         end

         assign load_en[j] = append && (len_ff == LEN_W'(j));
         assign active[j]  = (LEN_W'(j) < len_ff);

         ssoc_cell #(
            .COUNT_BITS (COUNT_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .load_en     (load_en[j]),
            .active      (active[j]),
            .lower_count (lower),
            .count_out   (count_q[j]),
            .count_next  (count_next[j]),
            .sat_hit     (sat_hits[j])
         );
      end
   endgenerate

   // The response reports the state after this beat, taken from the last
   // loaded cell; an empty pattern occurs exactly once.
   always_comb begin
      last_pos = len_in - LEN_W'(1);
      if (len_in == '0) begin
         total = COUNT_BITS'(1);
      end else begin
         total = count_next[last_pos[IDX_W-1:0]];
      end
      total_wide = {{COUNT_OUT_BITS{1'b0}}, total};
      len_wide   = {{LEN_OUT_BITS{1'b0}}, len_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         sat_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         sat_ff <= sat_in;
         ovf_ff <= ovf_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_count_ff <= total_wide[COUNT_OUT_BITS-1:0];
         rsp_sat_ff   <= sat_in;
         rsp_len_ff   <= len_wide[LEN_OUT_BITS-1:0];
         rsp_ovf_ff   <= ovf_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.count            = rsp_count_ff;
   assign rsp_bus.saturated        = rsp_sat_ff;
   assign rsp_bus.pattern_length   = rsp_len_ff;
   assign rsp_bus.pattern_overflow = rsp_ovf_ff;

endmodule

// ----- bench/subsequence_occurrence_counter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subsequence occurrence counter testbench
// Streams clear, pattern and text beats into the counter with random gaps on
// both channels and one long response stall. A behavioural tally of the
// pattern keys and partial counts predicts every response beat, and each
// response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module subsequence_occurrence_counter_test;
   import ssoc_pkg::*;

   localparam int MAX_PATTERN = MAX_PATTERN_DEF;
   localparam int COUNT_BITS  = COUNT_BITS_DEF;
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int ALPHA_W     = 2;
   localparam int ITEM_TARGET = 550;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 10;

   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [KEY_BITS-1:0]    value;
   } request_type;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] count;
      logic                      saturated;
      logic [LEN_OUT_BITS-1:0]   pattern_length;
      logic                      pattern_overflow;
   } tally_type;

   logic clock = 1'b0;
   logic reset;

   ssoc_req_if req_bus ();
   ssoc_rsp_if rsp_bus ();

   subsequence_occurrence_counter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted state of the counter row.
   logic [KEY_BITS-1:0]   key_row [MAX_PATTERN];
   logic [COUNT_BITS-1:0] partial [MAX_PATTERN];
   int                    loaded_len = 0;
   logic                  sat_flag = 1'b0;
   logic                  ovf_flag = 1'b0;

   request_type pending [$];
   tally_type   awaited_tallies [$];
   int          failures = 0;
   int          responses_seen = 0;
   int          cycle_count = 0;
   int          send_idle = 0;
   int          hold_left = 0;
   logic        long_hold_done = 1'b0;
   tally_type   got_tally, want_tally;
   request_type next_req;

   // A quarter of the time neither side idles.
   wire calm = ((cycle_count / 64) % 8) < 2;

   task automatic count_model_step(input request_type req, output tally_type tally);
      logic [COUNT_BITS:0]   sum;
      logic [COUNT_BITS-1:0] lower;
      case (req.action)
         ACT_CLEAR: begin
            loaded_len = 0;
            sat_flag   = 1'b0;
            ovf_flag   = 1'b0;
            foreach (partial[i]) partial[i] = '0;
         end
         ACT_PATTERN: begin
            if (loaded_len < MAX_PATTERN) begin
               key_row[IDX_W'(loaded_len)] = req.value;
               loaded_len++;
            end else begin
               ovf_flag = 1'b1;
            end
            foreach (partial[i]) partial[i] = '0;
         end
         ACT_TEXT: begin
            // Walk downwards so that every position sees the old lower count.
            for (int j = loaded_len - 1; j >= 0; j--) begin
               if (key_row[IDX_W'(j)] == req.value) begin
                  lower = (j == 0) ? COUNT_BITS'(1) : partial[IDX_W'(j-1)];
                  sum = {1'b0, partial[IDX_W'(j)]} + {1'b0, lower};
                  if (sum >= {1'b0, COUNT_MAX}) begin
                     partial[IDX_W'(j)] = COUNT_MAX;
                     sat_flag           = 1'b1;
                  end else begin
                     partial[IDX_W'(j)] = sum[COUNT_BITS-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
      tally.count            = (loaded_len == 0) ? COUNT_OUT_BITS'(1)
                               : COUNT_OUT_BITS'(partial[IDX_W'(loaded_len-1)]);
      tally.saturated        = sat_flag;
      tally.pattern_length   = LEN_OUT_BITS'(loaded_len);
      tally.pattern_overflow = ovf_flag;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_item(input logic [ACTION_BITS-1:0] action,
                             input logic [KEY_BITS-1:0] value);
      request_type r;
      r.action = action;
      r.value  = value;
      pending.push_back(r);
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
   endtask

   // Request driver: a new beat may be loaded once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            next_req.action = req_bus.action;
            next_req.value  = req_bus.value;
            count_model_step(next_req, want_tally);
            awaited_tallies.push_back(want_tally);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_bus.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               next_req = pending.pop_front();
               req_bus.action <= next_req.action;
               req_bus.value  <= next_req.value;
               req_bus.valid  <= 1'b1;
               send_idle = calm ? 0 : pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_tally.count            = rsp_bus.count;
            got_tally.saturated        = rsp_bus.saturated;
            got_tally.pattern_length   = rsp_bus.pattern_length;
            got_tally.pattern_overflow = rsp_bus.pattern_overflow;
            responses_seen++;
            if (awaited_tallies.size() == 0) begin
               $display("%0t: response beat with none expected, actual count %0d",
                        $time, got_tally.count);
               failures++;
            end else begin
               want_tally = awaited_tallies.pop_front();
               if (got_tally.count !== want_tally.count)
                  report_field("count", 64'(want_tally.count), 64'(got_tally.count));
               if (got_tally.saturated !== want_tally.saturated)
                  report_field("saturated", 64'(want_tally.saturated),
                               64'(got_tally.saturated));
               if (got_tally.pattern_length !== want_tally.pattern_length)
                  report_field("pattern_length", 64'(want_tally.pattern_length),
                               64'(got_tally.pattern_length));
               if (got_tally.pattern_overflow !== want_tally.pattern_overflow)
                  report_field("pattern_overflow", 64'(want_tally.pattern_overflow),
                               64'(got_tally.pattern_overflow));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && responses_seen >= 100) begin
            // One long stall so that the block backs up onto its input.
            long_hold_done = 1'b1;
            hold_left = 150;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            hold_left = pick_gap();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                  kind, plen, tlen, pick, alpha_n, seq_no;
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] alphabet [4];

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_CLEAR;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;

      // Directed opening: empty pattern, unknown action, signed zeros and NaNs
      // treated as distinct keys, and the all-ones key.
      queue_item(ACT_TEXT, 64'h0);
      queue_item(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(ACT_PATTERN, 64'h0);
      queue_item(ACT_PATTERN, 64'h8000_0000_0000_0000);
      queue_item(ACT_TEXT, 64'h8000_0000_0000_0000);
      queue_item(ACT_TEXT, 64'h0);
      queue_item(ACT_TEXT, 64'h8000_0000_0000_0000);
      queue_item(ACT_TEXT, 64'h7FF8_0000_0000_0000);
      queue_item(ACT_CLEAR, 64'h0);
      queue_item(ACT_PATTERN, 64'h7FF8_0000_0000_0000);
      queue_item(ACT_TEXT, 64'h7FF8_0000_0000_0001);
      queue_item(ACT_TEXT, 64'h7FF8_0000_0000_0000);
      queue_item(ACT_UNUSED, 64'h0);
      queue_item(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(ACT_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(ACT_TEXT, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(ACT_TEXT, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(ACT_CLEAR, 64'h0);

      seq_no = 0;
      while (pending.size() < ITEM_TARGET) begin
         kind = (seq_no == 0) ? 0 : $urandom_range(0, 11);
         seq_no++;
         if (kind == 0) begin
            // A full pattern of one repeated key saturates within about
            // forty text beats; further appends overflow but keep the flag.
            queue_item(ACT_CLEAR, random_key());
            key = random_key();
            repeat (MAX_PATTERN + 1) queue_item(ACT_PATTERN, key);
            repeat ($urandom_range(38, 44)) queue_item(ACT_TEXT, key);
            queue_item(ACT_PATTERN, key);
            repeat (3) queue_item(ACT_TEXT, key);
         end else if (kind == 1) begin
            repeat ($urandom_range(3, 8))
               queue_item(ACTION_BITS'($urandom_range(0, 3)), random_key());
         end else begin
            if ($urandom_range(0, 3) != 0) queue_item(ACT_CLEAR, random_key());
            alpha_n = $urandom_range(1, 4);
            for (int i = 0; i < alpha_n; i++) alphabet[ALPHA_W'(i)] = random_key();
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18)
                                               : $urandom_range(1, 6);
            repeat (plen)
               queue_item(ACT_PATTERN,
                          alphabet[ALPHA_W'($urandom_range(0, alpha_n-1))]);
            tlen = $urandom_range(4, 30);
            for (int i = 0; i < tlen; i++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  queue_item(ACT_PATTERN,
                             alphabet[ALPHA_W'($urandom_range(0, alpha_n-1))]);
               else if (pick == 1)
                  queue_item(ACT_UNUSED, random_key());
               else if (pick == 2)
                  queue_item(ACT_TEXT, random_key());
               else
                  queue_item(ACT_TEXT,
                             alphabet[ALPHA_W'($urandom_range(0, alpha_n-1))]);
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending.size() != 0 || req_bus.valid || awaited_tallies.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (awaited_tallies.size() != 0) begin
         $display("%0t: %0d expected response beats never arrived",
                  $time, awaited_tallies.size());
         failures++;
      end
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
